@@ rtl/eel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eel_pkg
// Shared constants and types for the emergency event log.
// ----------------------------------------------------------------------------
package eel_pkg;

    localparam int MINOR_DEPTH = 64;
    localparam int MAJOR_DEPTH = 32;

    localparam int NODE_W  = 8;
    localparam int CODE_W  = 32;
    localparam int PRIO_W  = 8;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 6;
    localparam int ENTRY_W = NODE_W + CODE_W;

    localparam logic [PRIO_W-1:0] PRIO_MAJOR = 8'h00;
    localparam logic [PRIO_W-1:0] PRIO_MINOR = 8'h01;

    typedef enum logic
    {
        CMD_LOG  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_LOGGED_MAJOR = 3'd0,
        ST_LOGGED_MINOR = 3'd1,
        ST_IGNORED      = 3'd2,
        ST_READ_HIT     = 3'd3,
        ST_READ_OOR     = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        FSM_IDLE,
        FSM_READ,
        FSM_DONE
    } fsm_t;

endpackage

@@ rtl/eel_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eel_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module eel_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/emergency_event_log.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emergency_event_log
// Two overwrite-oldest event logs (major and minor) with newest-first reads.
// ----------------------------------------------------------------------------
// One request at a time. A log request, an ignored request or an out-of-range
// read yields its result in the cycle after acceptance; a read hit first goes
// through the read state, where the entry is taken from the registered output
// of a log RAM. A new request is accepted only once the previous result has
// been taken. Each log is one RAM of depth N holding at most N-1 entries;
// when full, the oldest is overwritten.
module emergency_event_log
    import eel_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [PRIO_W-1:0]    priority_req,
    input  logic [NODE_W-1:0]    node_id,
    input  logic [CODE_W-1:0]    error_code,
    input  logic [IDX_W-1:0]     read_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [NODE_W-1:0]    entry_node,
    output logic [CODE_W-1:0]    entry_code,
    output logic [COUNT_W-1:0]   entry_count
);

    localparam int MAJ_AW = $clog2(MAJOR_DEPTH);
    localparam int MIN_AW = $clog2(MINOR_DEPTH);
    localparam int MAX_AW = (MAJ_AW > MIN_AW) ? MAJ_AW : MIN_AW;
    localparam int CW     = ((MAX_AW > IDX_W) ? MAX_AW : IDX_W) + 2;

    localparam logic [CW-1:0]     MAJ_D    = CW'(MAJOR_DEPTH);
    localparam logic [CW-1:0]     MIN_D    = CW'(MINOR_DEPTH);
    localparam logic [MAJ_AW-1:0] MAJ_LAST = MAJ_AW'(MAJOR_DEPTH - 1);
    localparam logic [MIN_AW-1:0] MIN_LAST = MIN_AW'(MINOR_DEPTH - 1);

    fsm_t                state_reg, state_next;
    logic [MAJ_AW-1:0]   maj_head_reg, maj_head_next;
    logic [MAJ_AW-1:0]   maj_tail_reg, maj_tail_next;
    logic [MIN_AW-1:0]   min_head_reg, min_head_next;
    logic [MIN_AW-1:0]   min_tail_reg, min_tail_next;
    status_t             status_reg, status_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                sel_minor_reg, sel_minor_next;

    logic                accept;
    logic                is_major;
    logic                is_minor;
    logic [CW-1:0]       maj_count;
    logic [CW-1:0]       min_count;
    logic [CW-1:0]       cur_count;
    logic [CW-1:0]       idx_ext;
    logic [CW-1:0]       maj_slot_sum;
    logic [CW-1:0]       min_slot_sum;
    logic [MAJ_AW-1:0]   maj_slot;
    logic [MIN_AW-1:0]   min_slot;
    logic [MAJ_AW-1:0]   maj_head_inc;
    logic [MIN_AW-1:0]   min_head_inc;
    logic [CW-1:0]       cur_last;

    logic                maj_wr_en, min_wr_en;
    logic                maj_rd_en, min_rd_en;
    logic [ENTRY_W-1:0]  wr_entry;
    logic [ENTRY_W-1:0]  maj_rd_data, min_rd_data;
    logic [ENTRY_W-1:0]  rd_entry;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != FSM_IDLE);
    assign is_major = (priority_req == PRIO_MAJOR);
    assign is_minor = (priority_req == PRIO_MINOR);
    assign wr_entry = {node_id, error_code};

    assign maj_count = (maj_head_reg >= maj_tail_reg)
                     ? CW'(maj_head_reg) - CW'(maj_tail_reg)
                     : CW'(maj_head_reg) + MAJ_D - CW'(maj_tail_reg);
    assign min_count = (min_head_reg >= min_tail_reg)
                     ? CW'(min_head_reg) - CW'(min_tail_reg)
                     : CW'(min_head_reg) + MIN_D - CW'(min_tail_reg);

    assign idx_ext   = CW'(read_index);
    assign cur_count = is_minor ? min_count : maj_count;
    assign cur_last  = is_minor ? (MIN_D - CW'(1)) : (MAJ_D - CW'(1));

    // newest-first slot: (head - 1 - index) mod depth
    assign maj_slot_sum = CW'(maj_head_reg) + MAJ_D - CW'(1) - idx_ext;
    assign min_slot_sum = CW'(min_head_reg) + MIN_D - CW'(1) - idx_ext;
    assign maj_slot = (maj_slot_sum >= MAJ_D) ? MAJ_AW'(maj_slot_sum - MAJ_D)
                                              : MAJ_AW'(maj_slot_sum);
    assign min_slot = (min_slot_sum >= MIN_D) ? MIN_AW'(min_slot_sum - MIN_D)
                                              : MIN_AW'(min_slot_sum);

    assign maj_head_inc = (maj_head_reg == MAJ_LAST) ? '0 : maj_head_reg + 1'b1;
    assign min_head_inc = (min_head_reg == MIN_LAST) ? '0 : min_head_reg + 1'b1;

    assign rd_entry = sel_minor_reg ? min_rd_data : maj_rd_data;

    always_comb
    begin
        state_next     = state_reg;
        maj_head_next  = maj_head_reg;
        maj_tail_next  = maj_tail_reg;
        min_head_next  = min_head_reg;
        min_tail_next  = min_tail_reg;
        status_next    = status_reg;
        node_next      = node_reg;
        code_next      = code_reg;
        count_next     = count_reg;
        sel_minor_next = sel_minor_reg;
        maj_wr_en      = 1'b0;
        min_wr_en      = 1'b0;
        maj_rd_en      = 1'b0;
        min_rd_en      = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next     = FSM_DONE;
                    node_next      = '0;
                    code_next      = '0;
                    count_next     = '0;
                    status_next    = ST_IGNORED;
                    sel_minor_next = is_minor;
                    if (is_major || is_minor)
                    begin
                        if (cmd_t'(command) == CMD_LOG)
                        begin
                            status_next = is_minor ? ST_LOGGED_MINOR : ST_LOGGED_MAJOR;
                            count_next  = (cur_count == cur_last)
                                        ? COUNT_W'(cur_count)
                                        : COUNT_W'(cur_count + CW'(1));
                            if (is_minor)
                            begin
                                min_wr_en     = 1'b1;
                                min_head_next = min_head_inc;
                                if (min_head_inc == min_tail_reg)
                                begin
                                    min_tail_next = (min_tail_reg == MIN_LAST)
                                                  ? '0 : min_tail_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                maj_wr_en     = 1'b1;
                                maj_head_next = maj_head_inc;
                                if (maj_head_inc == maj_tail_reg)
                                begin
                                    maj_tail_next = (maj_tail_reg == MAJ_LAST)
                                                  ? '0 : maj_tail_reg + 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            count_next = COUNT_W'(cur_count);
                            if (idx_ext < cur_count)
                            begin
                                status_next = ST_READ_HIT;
                                state_next  = FSM_READ;
                                min_rd_en   = is_minor;
                                maj_rd_en   = is_major;
                            end
                            else
                            begin
                                status_next = ST_READ_OOR;
                            end
                        end
                    end
                end
            end
            FSM_READ:
            begin
                node_next  = rd_entry[ENTRY_W-1:CODE_W];
                code_next  = rd_entry[CODE_W-1:0];
                state_next = FSM_DONE;
            end
            FSM_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_IDLE;
            maj_head_reg <= '0;
            maj_tail_reg <= '0;
            min_head_reg <= '0;
            min_tail_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            maj_head_reg <= maj_head_next;
            maj_tail_reg <= maj_tail_next;
            min_head_reg <= min_head_next;
            min_tail_reg <= min_tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        node_reg      <= node_next;
        code_reg      <= code_next;
        count_reg     <= count_next;
        sel_minor_reg <= sel_minor_next;
    end

    eel_ram #(
        .DEPTH (MAJOR_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_major_ram (
        .clk     (clk),
        .wr_en   (maj_wr_en),
        .wr_addr (maj_head_reg),
        .wr_data (wr_entry),
        .rd_en   (maj_rd_en),
        .rd_addr (maj_slot),
        .rd_data (maj_rd_data)
    );

    eel_ram #(
        .DEPTH (MINOR_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_minor_ram (
        .clk     (clk),
        .wr_en   (min_wr_en),
        .wr_addr (min_head_reg),
        .wr_data (wr_entry),
        .rd_en   (min_rd_en),
        .rd_addr (min_slot),
        .rd_data (min_rd_data)
    );

    assign out_valid   = (state_reg == FSM_DONE);
    assign status      = status_reg;
    assign entry_node  = node_reg;
    assign entry_code  = code_reg;
    assign entry_count = count_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the emergency event log. A short table of requests
// covers reset state, field extremes, ignored priorities and range errors;
// a random phase then fills, wraps and reads back both logs. Every request is
// run through a local model of both logs and each result is compared in order.
// ----------------------------------------------------------------------------
module tb;
    import eel_pkg::*;

    localparam int RANDOM_ITEMS     = 1600;
    localparam int QUIET_ITEMS      = 200;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int TAIL_CYCLES      = 10;
    localparam int DIR_ROWS         = 22;

    typedef struct packed
    {
        status_t              status;
        logic [NODE_W-1:0]    node;
        logic [CODE_W-1:0]    code;
        logic [COUNT_W-1:0]   count;
    } log_result_t;

    typedef struct packed
    {
        cmd_t                 cmd;
        logic [PRIO_W-1:0]    prio;
        logic [NODE_W-1:0]    node;
        logic [CODE_W-1:0]    code;
        logic [IDX_W-1:0]     idx;
        logic                 pinned;
        status_t              exp_status;
        logic [NODE_W-1:0]    exp_node;
        logic [CODE_W-1:0]    exp_code;
        logic [COUNT_W-1:0]   exp_count;
    } req_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic [PRIO_W-1:0]    priority_req;
    logic [NODE_W-1:0]    node_id;
    logic [CODE_W-1:0]    error_code;
    logic [IDX_W-1:0]     read_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           status;
    logic [NODE_W-1:0]    entry_node;
    logic [CODE_W-1:0]    entry_code;
    logic [COUNT_W-1:0]   entry_count;

    // model of both logs: index 0 major, 1 minor
    logic [ENTRY_W-1:0]   log_mem [2][MINOR_DEPTH];
    int unsigned          log_head [2];
    int unsigned          log_tail [2];

    log_result_t          pending_results [$];
    log_result_t          pinned_result;
    bit                   pinned_en;
    int                   mismatch_cnt;
    bit                   quiet;
    bit                   long_hold_req;

    req_row_t directed_tbl [DIR_ROWS] = '{
        '{CMD_READ, PRIO_MAJOR, 8'h00, 32'h00000000, 6'd0,  1'b1,
          ST_READ_OOR, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, PRIO_MINOR, 8'hff, 32'hffffffff, 6'd63, 1'b1,
          ST_READ_OOR, 8'h00, 32'h00000000, 6'd0},
        '{CMD_LOG,  8'h02,      8'hab, 32'h12345678, 6'd0,  1'b1,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, 8'hff,      8'h00, 32'h00000000, 6'd0,  1'b1,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_LOG,  8'hff,      8'hff, 32'hffffffff, 6'd63, 1'b1,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_LOG,  PRIO_MAJOR, 8'h00, 32'h00000000, 6'd0,  1'b1,
          ST_LOGGED_MAJOR, 8'h00, 32'h00000000, 6'd1},
        '{CMD_LOG,  PRIO_MINOR, 8'hff, 32'hffffffff, 6'd63, 1'b1,
          ST_LOGGED_MINOR, 8'h00, 32'h00000000, 6'd1},
        '{CMD_READ, PRIO_MAJOR, 8'hff, 32'hffffffff, 6'd0,  1'b1,
          ST_READ_HIT, 8'h00, 32'h00000000, 6'd1},
        '{CMD_READ, PRIO_MINOR, 8'h00, 32'h00000000, 6'd0,  1'b1,
          ST_READ_HIT, 8'hff, 32'hffffffff, 6'd1},
        '{CMD_READ, PRIO_MINOR, 8'h00, 32'h00000000, 6'd1,  1'b1,
          ST_READ_OOR, 8'h00, 32'h00000000, 6'd1},
        '{CMD_READ, PRIO_MAJOR, 8'h00, 32'h00000000, 6'd63, 1'b1,
          ST_READ_OOR, 8'h00, 32'h00000000, 6'd1},
        '{CMD_LOG,  PRIO_MAJOR, 8'h5a, 32'hdeadbeef, 6'd0,  1'b0,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_LOG,  PRIO_MINOR, 8'ha5, 32'h80000001, 6'd0,  1'b0,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_LOG,  8'h80,      8'h01, 32'h00000001, 6'd0,  1'b1,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, PRIO_MAJOR, 8'h00, 32'h00000000, 6'd1,  1'b0,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, PRIO_MAJOR, 8'h00, 32'h00000000, 6'd0,  1'b0,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, PRIO_MINOR, 8'h00, 32'h00000000, 6'd1,  1'b0,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, 8'h02,      8'h00, 32'h00000000, 6'd0,  1'b1,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, 8'hfe,      8'h00, 32'h00000000, 6'd63, 1'b1,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_LOG,  PRIO_MINOR, 8'h00, 32'h00000000, 6'd0,  1'b0,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, PRIO_MINOR, 8'h00, 32'h00000000, 6'd2,  1'b0,
          ST_IGNORED, 8'h00, 32'h00000000, 6'd0},
        '{CMD_READ, PRIO_MINOR, 8'h00, 32'h00000000, 6'd3,  1'b1,
          ST_READ_OOR, 8'h00, 32'h00000000, 6'd3}
    };

    emergency_event_log DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .priority_req (priority_req),
        .node_id      (node_id),
        .error_code   (error_code),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .entry_node   (entry_node),
        .entry_code   (entry_code),
        .entry_count  (entry_count)
    );

    function automatic int unsigned log_depth(input bit sel);
        return sel ? MINOR_DEPTH : MAJOR_DEPTH;
    endfunction

    function automatic int unsigned log_fill(input bit sel);
        return (log_head[sel] + log_depth(sel) - log_tail[sel]) % log_depth(sel);
    endfunction

    function automatic log_result_t predict_log_access(
        input cmd_t               cmd,
        input logic [PRIO_W-1:0]  prio,
        input logic [NODE_W-1:0]  node,
        input logic [CODE_W-1:0]  code,
        input logic [IDX_W-1:0]   idx
    );
        log_result_t  res;
        bit           sel;
        int unsigned  d;
        int unsigned  nxt;
        int unsigned  slot;
        res = '{status: ST_IGNORED, node: '0, code: '0, count: '0};
        if (prio == PRIO_MAJOR || prio == PRIO_MINOR)
        begin
            sel = prio[0];
            d = log_depth(sel);
            if (cmd == CMD_LOG)
            begin
                log_mem[sel][log_head[sel]] = {node, code};
                nxt = (log_head[sel] + 1) % d;
                if (nxt == log_tail[sel])
                    log_tail[sel] = (log_tail[sel] + 1) % d;
                log_head[sel] = nxt;
                res.status = sel ? ST_LOGGED_MINOR : ST_LOGGED_MAJOR;
            end
            else if (idx < log_fill(sel))
            begin
                slot = (log_head[sel] + 2 * d - 1 - idx) % d;
                {res.node, res.code} = log_mem[sel][slot];
                res.status = ST_READ_HIT;
            end
            else
            begin
                res.status = ST_READ_OOR;
            end
            res.count = COUNT_W'(log_fill(sel));
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input bit sel);
        int unsigned cnt;
        int unsigned r;
        cnt = log_fill(sel);
        r = $urandom_range(0, 9);
        if (r < 7)
            return IDX_W'($urandom_range(0, (cnt == 0) ? 0 : cnt - 1));
        else if (r < 9)
            return IDX_W'(cnt);
        return IDX_W'($urandom_range(0, 63));
    endfunction

    task automatic send_req(
        input cmd_t               cmd,
        input logic [PRIO_W-1:0]  prio,
        input logic [NODE_W-1:0]  node,
        input logic [CODE_W-1:0]  code,
        input logic [IDX_W-1:0]   idx,
        input bit                 pin,
        input log_result_t        pin_res
    );
        int n;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        priority_req <= prio;
        node_id      <= node;
        error_code   <= code;
        read_index   <= idx;
        pinned_en     = pin;
        pinned_result = pin_res;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stall bursts, one long hold on request
    initial
    begin : rx_side
        int hold_cnt;
        hold_cnt  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_cnt = LONG_HOLD_CYCLES;
            end
            else if (hold_cnt == 0 && !quiet && $urandom_range(0, 7) == 0)
            begin
                hold_cnt = $urandom_range(1, 13);
            end
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        log_result_t exp_res;
        log_result_t pred;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result with nothing pending: status %0d", $realtime,
                                 status);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (status !== exp_res.status || entry_node !== exp_res.node ||
                        entry_code !== exp_res.code || entry_count !== exp_res.count)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("%0t: mismatch exp st=%0d node=%h code=%h cnt=%0d",
                                     $realtime, exp_res.status, exp_res.node, exp_res.code,
                                     exp_res.count);
                            $display("%0t:          got st=%0d node=%h code=%h cnt=%0d",
                                     $realtime, status, entry_node, entry_code,
                                     entry_count);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pred = predict_log_access(cmd_t'(command), priority_req, node_id,
                                          error_code, read_index);
                pending_results.push_back(pinned_en ? pinned_result : pred);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        req_row_t           row;
        log_result_t        pin_res;
        log_result_t        none;
        cmd_t               cmd;
        logic [PRIO_W-1:0]  prio;
        logic [NODE_W-1:0]  node;
        logic [CODE_W-1:0]  code;
        logic [IDX_W-1:0]   idx;
        int                 real_cnt;
        int                 seg_no;
        int                 seg_left;
        int                 seg_mode;
        bit                 seg_sel;
        bit                 hold_done;
        bit                 drain_done;
        int                 r;

        none          = '{status: ST_IGNORED, node: '0, code: '0, count: '0};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_LOG;
        priority_req  = '0;
        node_id       = '0;
        error_code    = '0;
        read_index    = '0;
        pinned_en     = 1'b0;
        pinned_result = none;
        mismatch_cnt  = 0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < MINOR_DEPTH; i++)
                log_mem[s][i] = '0;
        log_head = '{0, 0};
        log_tail = '{0, 0};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = directed_tbl[i];
            pin_res = '{status: row.exp_status, node: row.exp_node, code: row.exp_code,
                        count: row.exp_count};
            send_req(row.cmd, row.prio, row.node, row.code, row.idx, row.pinned, pin_res);
        end

        real_cnt   = 0;
        seg_no     = 0;
        seg_left   = 0;
        seg_mode   = 0;
        seg_sel    = 1'b0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (real_cnt < RANDOM_ITEMS)
        begin
            if (seg_left == 0)
            begin
                // open with a wrap of each log, then random segments
                if (seg_no == 0)
                begin
                    seg_mode = 0; seg_sel = 1'b0; seg_left = 40;
                end
                else if (seg_no == 1)
                begin
                    seg_mode = 0; seg_sel = 1'b1; seg_left = 70;
                end
                else
                begin
                    seg_mode = $urandom_range(0, 2);
                    seg_sel  = 1'($urandom_range(0, 1));
                    seg_left = (seg_mode == 0) ? $urandom_range(1, 80) : $urandom_range(4, 40);
                end
                seg_no++;
            end
            seg_left--;

            cmd  = CMD_LOG;
            prio = {7'b0, seg_sel};
            node = NODE_W'($urandom_range(0, 255));
            code = $urandom;
            idx  = IDX_W'($urandom_range(0, 63));
            r = $urandom_range(0, 31);
            if (r == 0)
            begin
                node = '1;
                code = '1;
            end
            else if (r == 1)
            begin
                node = '0;
                code = '0;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                prio = PRIO_W'($urandom_range(0, 255));
                cmd  = cmd_t'($urandom_range(0, 1));
            end
            else
            begin
                case (seg_mode)
                    0: cmd = CMD_LOG;
                    1:
                    begin
                        cmd = CMD_READ;
                        idx = pick_index(seg_sel);
                    end
                    default:
                    begin
                        prio = PRIO_W'($urandom_range(0, 1));
                        cmd  = cmd_t'($urandom_range(0, 1));
                        if (cmd == CMD_READ)
                            idx = pick_index(prio[0]);
                    end
                endcase
            end

            if (prio == PRIO_MAJOR || prio == PRIO_MINOR)
                real_cnt++;
            if (real_cnt >= 300 && !hold_done)
            begin
                hold_done = 1'b1;
                long_hold_req = 1'b1;
            end
            if (real_cnt >= 700 && !drain_done)
            begin
                drain_done = 1'b1;
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(negedge clk);
            end
            quiet = (real_cnt >= RANDOM_ITEMS - QUIET_ITEMS);
            send_req(cmd, prio, node, code, idx, 1'b0, none);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        mismatch_cnt += pending_results.size();
        if (mismatch_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
